// ===== rtl/write_record_fifo_offset_lookup_assert.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef WRITE_RECORD_FIFO_OFFSET_LOOKUP_ASSERT_SVH
`define WRITE_RECORD_FIFO_OFFSET_LOOKUP_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define WRFL_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication.
`define WRFL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define WRFL_ASSERT_NOW(label, clk, rst, ante, cons)
`define WRFL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/wrfl_pkg.sv =====
package wrfl_pkg;

   localparam int REQ_W     = 2;
   localparam int HANDLE_W  = 32;
   localparam int LEN_W     = 16;
   localparam int POS_W     = 20;
   localparam int OFS_W     = 16;
   localparam int DEPTH_DEF = 16;

   typedef enum logic [REQ_W-1:0] {
      REQ_ADD    = 2'd0,
      REQ_REMOVE = 2'd1,
      REQ_FIND   = 2'd2
   } req_code_type;

   // per-cell control from the top level
   typedef struct packed {
      logic shift;   // take neighbor's record
      logic load;    // take the appended record
      logic active;  // cell holds a stored record
   } cell_ctrl_type;

endpackage

// ===== rtl/wrfl_cell.sv =====
module wrfl_cell #(
   parameter int BASE_W = 21
) (
   input  logic                           clock,
   input  wrfl_pkg::cell_ctrl_type        ctrl,
   input  logic [wrfl_pkg::HANDLE_W-1:0]  nb_handle,
   input  logic [wrfl_pkg::LEN_W-1:0]     nb_length,
   input  logic [BASE_W-1:0]              nb_base,
   input  logic [wrfl_pkg::LEN_W-1:0]     drop_length,
   input  logic [wrfl_pkg::HANDLE_W-1:0]  new_handle,
   input  logic [wrfl_pkg::LEN_W-1:0]     new_length,
   input  logic [BASE_W-1:0]              new_base,
   input  logic [wrfl_pkg::POS_W-1:0]     find_pos,
   output logic [wrfl_pkg::HANDLE_W-1:0]  handle,
   output logic [wrfl_pkg::LEN_W-1:0]     length,
   output logic [BASE_W-1:0]              base,
   output logic                           hit,
   output logic [wrfl_pkg::HANDLE_W-1:0]  sel_handle,
   output logic [wrfl_pkg::LEN_W-1:0]     sel_length,
   output logic [wrfl_pkg::OFS_W-1:0]     sel_offset
);
   import wrfl_pkg::*;

   localparam int CMP_W = ((BASE_W > POS_W) ? BASE_W : POS_W) + 1;

   logic [HANDLE_W-1:0] handle_ff, handle_in;
   logic [LEN_W-1:0]    length_ff, length_in;
   logic [BASE_W-1:0]   base_ff, base_in;
   logic [CMP_W-1:0]    pos_x, lo_x, hi_x, diff_x;

   always_comb begin
      handle_in = handle_ff;
      length_in = length_ff;
      base_in   = base_ff;
      if (ctrl.load) begin
         handle_in = new_handle;
         length_in = new_length;
         base_in   = new_base;
      end else if (ctrl.shift) begin
         handle_in = nb_handle;
         length_in = nb_length;
         // starts move down by the dropped record's length
         base_in   = nb_base - BASE_W'(drop_length);
      end
   end

   always_ff @(posedge clock) begin
      handle_ff <= handle_in;
      length_ff <= length_in;
      base_ff   <= base_in;
   end

   // byte range [base, base + length)
   assign pos_x  = CMP_W'(find_pos);
   assign lo_x   = CMP_W'(base_ff);
   assign hi_x   = CMP_W'(base_ff) + CMP_W'(length_ff);
   assign diff_x = pos_x - lo_x;
   assign hit    = ctrl.active && (pos_x >= lo_x) && (pos_x < hi_x);

   assign handle     = handle_ff;
   assign length     = length_ff;
   assign base       = base_ff;
   assign sel_handle = hit ? handle_ff : '0;
   assign sel_length = hit ? length_ff : '0;
   assign sel_offset = hit ? diff_x[OFS_W-1:0] : '0;

endmodule

// ===== rtl/write_record_fifo_offset_lookup.sv =====
// Channel | Dir | Payload
// req_*   | in  | tuser: req_type; tdata: add_handle, add_length, byte_position
// rsp_*   | out | tuser: hit; tdata: record_handle, record_length,
//         |     |        offset_in_record, record_count, is_full
//
// One request per cycle while req_tready is high; its response is registered and shows the next cycle.
// Records sit in a row of cells, oldest in cell 0; each cell keeps its start
// offset, so add, remove and find all finish in the cycle of acceptance.
// req_tready is high while the response register is empty or being taken.
// Synchronous reset empties the store; no clearing pass is needed.
`include "write_record_fifo_offset_lookup_assert.svh"

module write_record_fifo_offset_lookup #(
   parameter int   DEPTH  = wrfl_pkg::DEPTH_DEF,
   localparam int  CNT_W  = $clog2(DEPTH + 1),
   localparam int  RSP_W  = ((2 * wrfl_pkg::LEN_W + wrfl_pkg::HANDLE_W + CNT_W + 1 + 7) / 8) * 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [1:0] req_type
   input  logic [wrfl_pkg::REQ_W-1:0]    req_tuser,
   // [31:0] add_handle, [47:32] add_length, [67:48] byte_position, rest zero
   input  logic [71:0]                   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [0] hit
   output logic                          rsp_tuser,
   // [31:0] record_handle, [47:32] record_length, [63:48] offset_in_record,
   // then record_count (CNT_W bits), then is_full, rest zero
   output logic [RSP_W-1:0]              rsp_tdata
);
   import wrfl_pkg::*;

   localparam int BASE_W = LEN_W + $clog2(DEPTH + 1);

   // request fields
   logic [HANDLE_W-1:0] add_handle;
   logic [LEN_W-1:0]    add_length;
   logic [POS_W-1:0]    byte_position;
   logic                accept;

   // store status
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              full_ff, full_in;
   logic [BASE_W-1:0] total_ff, total_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_hit_ff, rsp_hit_in;
   logic [HANDLE_W-1:0] rsp_handle_ff, rsp_handle_in;
   logic [LEN_W-1:0]    rsp_length_ff, rsp_length_in;
   logic [OFS_W-1:0]    rsp_offset_ff, rsp_offset_in;

   // cell row; index DEPTH is the empty slot past the last cell
   logic [HANDLE_W-1:0] c_handle [DEPTH+1];
   logic [LEN_W-1:0]    c_length [DEPTH+1];
   logic [BASE_W-1:0]   c_base   [DEPTH+1];
   logic [DEPTH-1:0]    c_hit;
   logic [HANDLE_W-1:0] c_sel_handle [DEPTH];
   logic [LEN_W-1:0]    c_sel_length [DEPTH];
   logic [OFS_W-1:0]    c_sel_offset [DEPTH];
   cell_ctrl_type       c_ctrl [DEPTH];

   logic                do_add, do_shift;
   logic [BASE_W-1:0]   new_base;
   logic                find_hit;
   logic [HANDLE_W-1:0] find_handle;
   logic [LEN_W-1:0]    find_length;
   logic [OFS_W-1:0]    find_offset;

   // assertion helpers
   logic                count_at_depth;
   logic                pop_req;
   logic [CNT_W-1:0]    count_dec;
   logic                rsp_fields_zero;

   assign add_handle    = req_tdata[HANDLE_W-1:0];
   assign add_length    = req_tdata[HANDLE_W +: LEN_W];
   assign byte_position = req_tdata[HANDLE_W+LEN_W +: POS_W];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // add, or pop when not empty; add to a full store also drops the oldest
   always_comb begin
      do_add   = 1'b0;
      do_shift = 1'b0;
      if (accept) begin
         case (req_tuser)
            REQ_ADD: begin
               do_add   = 1'b1;
               do_shift = full_ff;
            end
            REQ_REMOVE: do_shift = (count_ff != '0);
            default: ;
         endcase
      end
   end

   // start offset of the appended record
   assign new_base = full_ff ? (total_ff - BASE_W'(c_length[0])) : total_ff;

   assign c_handle[DEPTH] = '0;
   assign c_length[DEPTH] = '0;
   assign c_base[DEPTH]   = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      always_comb begin
         c_ctrl[i].shift  = do_shift;
         c_ctrl[i].load   = do_add &&
                            (full_ff ? (i == DEPTH - 1) : (CNT_W'(i) == count_ff));
         c_ctrl[i].active = (CNT_W'(i) < count_ff);
      end

      wrfl_cell #(
         .BASE_W (BASE_W)
      ) u_cell (
         .clock       (clock),
         .ctrl        (c_ctrl[i]),
         .nb_handle   (c_handle[i+1]),
         .nb_length   (c_length[i+1]),
         .nb_base     (c_base[i+1]),
         .drop_length (c_length[0]),
         .new_handle  (add_handle),
         .new_length  (add_length),
         .new_base    (new_base),
         .find_pos    (byte_position),
         .handle      (c_handle[i]),
         .length      (c_length[i]),
         .base        (c_base[i]),
         .hit         (c_hit[i]),
         .sel_handle  (c_sel_handle[i]),
         .sel_length  (c_sel_length[i]),
         .sel_offset  (c_sel_offset[i])
      );
   end

   // Nonzero-length ranges are disjoint, so at most one cell hits: plain OR.
   always_comb begin
      find_hit    = |c_hit;
      find_handle = '0;
      find_length = '0;
      find_offset = '0;
      for (int i = 0; i < DEPTH; i++) begin
         find_handle = find_handle | c_sel_handle[i];
         find_length = find_length | c_sel_length[i];
         find_offset = find_offset | c_sel_offset[i];
      end
   end

   // status and response next values
   always_comb begin
      count_in      = count_ff;
      full_in       = full_ff;
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_hit_in    = rsp_hit_ff;
      rsp_handle_in = rsp_handle_ff;
      rsp_length_in = rsp_length_ff;
      rsp_offset_in = rsp_offset_ff;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_hit_in    = 1'b0;
         rsp_handle_in = '0;
         rsp_length_in = '0;
         rsp_offset_in = '0;
         case (req_tuser)
            REQ_ADD: begin
               total_in = new_base + BASE_W'(add_length);
               if (!full_ff) begin
                  count_in = count_ff + CNT_W'(1);
                  full_in  = (count_in == CNT_W'(DEPTH));
               end
            end
            REQ_REMOVE: begin
               if (count_ff != '0) begin
                  count_in      = count_ff - CNT_W'(1);
                  full_in       = 1'b0;
                  total_in      = total_ff - BASE_W'(c_length[0]);
                  rsp_hit_in    = 1'b1;
                  rsp_handle_in = c_handle[0];
                  rsp_length_in = c_length[0];
               end
            end
            REQ_FIND: begin
               rsp_hit_in    = find_hit;
               rsp_handle_in = find_handle;
               rsp_length_in = find_length;
               rsp_offset_in = find_offset;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         full_ff      <= 1'b0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         full_ff      <= full_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_hit_ff    <= rsp_hit_in;
      rsp_handle_ff <= rsp_handle_in;
      rsp_length_ff <= rsp_length_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = RSP_W'({full_ff, count_ff, rsp_offset_ff, rsp_length_ff,
                               rsp_handle_ff});

   assign count_at_depth  = (count_ff == CNT_W'(DEPTH));
   assign pop_req         = accept && (req_tuser == REQ_REMOVE) && (count_ff != '0);
   assign count_dec       = count_ff - CNT_W'(1);
   assign rsp_fields_zero = (rsp_handle_ff == '0) && (rsp_length_ff == '0) &&
                            (rsp_offset_ff == '0);

   `WRFL_ASSERT_NOW(a_full_tracks_count, clock, reset, 1'b1, full_ff == count_at_depth)
   `WRFL_ASSERT_NOW(a_count_in_range, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))
   `WRFL_ASSERT_NEXT(a_accept_gives_rsp, clock, reset, accept, rsp_valid_ff)
   `WRFL_ASSERT_NEXT(a_pop_decrements, clock, reset, pop_req, count_ff == $past(count_dec))
   `WRFL_ASSERT_NOW(a_miss_fields_zero, clock, reset, rsp_valid_ff && !rsp_hit_ff, rsp_fields_zero)

endmodule

// ===== dv/write_record_fifo_offset_lookup_test.sv =====
// Self-checking bench for the write-record store with byte-offset lookup.
// Requests come from a queue filled by the stimulus process; a clocked driver
// offers them on req_*, a clocked monitor predicts each accepted request and
// compares every rsp_* response against the oldest prediction.
module write_record_fifo_offset_lookup_test;
   timeunit 1ns;
   timeprecision 1ps;

   import wrfl_pkg::*;

   localparam int DEPTH        = DEPTH_DEF;
   localparam int CNT_W        = $clog2(DEPTH + 1);
   localparam int RSP_W        = ((2 * LEN_W + HANDLE_W + CNT_W + 1 + 7) / 8) * 8;
   localparam int SEGMENTS     = 50;
   localparam int SEG_ITEMS    = 40;
   localparam int LONG_HOLD    = 200;   // receiver hold-off, cycles
   localparam int STALL_LIMIT  = 2000;  // cycles with no handshake before giving up
   localparam int DRAIN_CYCLES = 10;
   localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;  // undefined code, no-op

   // one request as the block sees it
   typedef struct packed {
      logic [REQ_W-1:0]    op;
      logic [HANDLE_W-1:0] handle;
      logic [LEN_W-1:0]    length;
      logic [POS_W-1:0]    pos;
   } record_req_type;

   // one response, unpacked from rsp_tuser / rsp_tdata
   typedef struct packed {
      logic                hit;
      logic [HANDLE_W-1:0] handle;
      logic [LEN_W-1:0]    length;
      logic [OFS_W-1:0]    offset;
      logic [CNT_W-1:0]    count;
      logic                full;
   } record_rsp_type;

   // record store, oldest in slot 0
   typedef struct {
      logic [HANDLE_W-1:0] handle[DEPTH];
      logic [LEN_W-1:0]    length[DEPTH];
      int unsigned         count;
   } record_store_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_W-1:0]    req_tuser  = '0;
   logic [71:0]         req_tdata  = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic                rsp_tuser;
   logic [RSP_W-1:0]    rsp_tdata;

   record_req_type   pending_requests[$];
   record_rsp_type   expected_responses[$];
   record_store_type store_model;   // mirrors the block, advanced on acceptance
   record_store_type plan_store;    // advanced at generation, steers find offsets

   bit          calm = 1'b0;       // no random idling on either side
   int unsigned hold_trigger = 0;  // bump to start one long receiver hold-off
   int unsigned quiet_cycles = 0;
   int unsigned errors = 0;
   int unsigned rsp_index = 0;
   int unsigned n_add = 0, n_remove = 0, n_find = 0, n_reserved = 0;
   int unsigned find_hits = 0, remove_hits = 0, full_seen = 0;

   write_record_fifo_offset_lookup #(.DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),   // [1:0] req_type
      .req_tdata  (req_tdata),   // handle, length, byte_position, 4 zero bits
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),   // [0] hit
      .rsp_tdata  (rsp_tdata)    // handle, length, offset, count, full, zeros
   );

   always #1 clock = ~clock;

   // ---------------------------------------------------------------- predictor
   function automatic void drop_oldest(inout record_store_type s);
      for (int i = 0; i + 1 < DEPTH; i++) begin
         s.handle[i] = s.handle[i + 1];
         s.length[i] = s.length[i + 1];
      end
   endfunction

   function automatic record_rsp_type apply_record_request(inout record_store_type s,
                                                           input record_req_type r);
      record_rsp_type o;
      int unsigned base;
      o    = '0;
      base = 0;
      case (r.op)
         REQ_ADD: begin
            // full store: oldest record falls out, count stays at DEPTH
            if (s.count == DEPTH) begin
               drop_oldest(s);
               s.count = DEPTH - 1;
            end
            s.handle[s.count] = r.handle;
            s.length[s.count] = r.length;
            s.count++;
         end
         REQ_REMOVE: begin
            // empty store: miss, nothing moves
            if (s.count > 0) begin
               o.hit    = 1'b1;
               o.handle = s.handle[0];
               o.length = s.length[0];
               drop_oldest(s);
               s.count--;
            end
         end
         REQ_FIND: begin
            // walk the concatenation; zero-length records are never chosen
            for (int unsigned i = 0; i < s.count; i++) begin
               if (!o.hit && r.pos >= base && r.pos < base + s.length[i]) begin
                  o.hit    = 1'b1;
                  o.handle = s.handle[i];
                  o.length = s.length[i];
                  o.offset = OFS_W'(r.pos - base);
               end
               base += s.length[i];
            end
         end
         default: ;  // reserved code: report state only
      endcase
      o.count = CNT_W'(s.count);
      o.full  = (s.count == DEPTH);
      return o;
   endfunction

   function automatic int unsigned stored_bytes(input record_store_type s);
      int unsigned sum;
      sum = 0;
      for (int unsigned i = 0; i < s.count; i++) sum += s.length[i];
      return sum;
   endfunction

   // ---------------------------------------------------------------- stimulus
   task automatic queue_request(input logic [REQ_W-1:0] op, input logic [31:0] handle,
                                input logic [15:0] length, input logic [19:0] pos);
      record_req_type r;
      record_rsp_type unused;
      r = '{op: op, handle: handle, length: length, pos: pos};
      unused = apply_record_request(plan_store, r);
      pending_requests.push_back(r);
   endtask

   function automatic logic [15:0] pick_length();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) return 16'($urandom_range(0, 15));
      if (roll < 75) return 16'($urandom_range(0, 255));
      if (roll < 90) return 16'($urandom());
      return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
   endfunction

   // mostly offsets inside the stored bytes, some right past the end, some anywhere
   function automatic logic [19:0] pick_offset();
      int unsigned total, roll;
      total = stored_bytes(plan_store);
      roll  = $urandom_range(0, 99);
      if (total > 0 && roll < 80) return 20'($urandom_range(0, total - 1));
      if (roll < 90) return 20'(total + $urandom_range(0, 2));
      return 20'($urandom());
   endfunction

   // mode 0 leans to adds (keeps the store full), 1 to removes, 2 in between with more adds
   task automatic queue_random(input int unsigned mode);
      int unsigned roll, add_cut, rem_cut;
      logic [REQ_W-1:0] op;
      roll    = $urandom_range(0, 99);
      add_cut = (mode == 0) ? 55 : (mode == 1) ? 25 : 38;
      rem_cut = (mode == 0) ? 70 : (mode == 1) ? 65 : 62;
      if (roll < add_cut)      op = REQ_ADD;
      else if (roll < rem_cut) op = REQ_REMOVE;
      else if (roll < 95)      op = REQ_FIND;
      else                     op = REQ_RESERVED;
      queue_request(op, $urandom(), pick_length(), pick_offset());
   endtask

   // checked between edges, once driver and monitor updates have settled
   task automatic wait_for_drain();
      @(negedge clock);
      while (pending_requests.size() != 0 || req_tvalid || expected_responses.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      plan_store  = '{default: '0};
      store_model = '{default: '0};
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: empty store, zero-length record, field extremes,
      // offset edges, overwrite of the oldest when full
      queue_request(REQ_REMOVE,   32'h1234_5678, 16'h0001, 20'h00000);
      queue_request(REQ_FIND,     32'h0,         16'h0,    20'h00000);
      queue_request(REQ_RESERVED, 32'hFFFF_FFFF, 16'hFFFF, 20'hFFFFF);
      queue_request(REQ_ADD,      32'h0000_0000, 16'h0000, 20'h00000);
      queue_request(REQ_ADD,      32'hFFFF_FFFF, 16'hFFFF, 20'hFFFFF);
      queue_request(REQ_ADD,      32'hA5A5_5A5A, 16'h0001, 20'h00000);
      queue_request(REQ_FIND,     32'h0,         16'h0,    20'h00000);  // skips empty record
      queue_request(REQ_FIND,     32'h0,         16'h0,    20'h0FFFE);
      queue_request(REQ_FIND,     32'h0,         16'h0,    20'h0FFFF);  // lands in third
      queue_request(REQ_FIND,     32'h0,         16'h0,    20'h10000);  // just past the end
      queue_request(REQ_FIND,     32'h0,         16'h0,    20'hFFFFF);
      queue_request(REQ_RESERVED, 32'h0,         16'h0,    20'h0);
      for (int i = 0; i < 14; i++)
         queue_request(REQ_ADD, $urandom(), 16'hFFFF, 20'h0);  // last one overwrites
      queue_request(REQ_FIND,     32'h0,         16'h0,    20'hEFFF1);  // last byte stored
      queue_request(REQ_REMOVE,   32'h0,         16'h0,    20'h0);
      wait_for_drain();

      // random segments, topped up as the driver consumes them
      for (int s = 0; s < SEGMENTS; s++) begin
         int unsigned mode;
         mode = $urandom_range(0, 2);
         calm = (s >= 12 && s < 18);
         if (s == 25) hold_trigger++;   // sender keeps offering through this
         for (int k = 0; k < SEG_ITEMS; k++) queue_random(mode);
         if (s == 35) wait_for_drain(); // sender pauses until all responses are in
         else while (pending_requests.size() > 4) @(posedge clock);
      end

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_responses.size() != 0) begin
         errors += expected_responses.size();
         $display("%0d responses never arrived", expected_responses.size());
      end
      $display("Ran %0d requests: %0d add, %0d remove, %0d find, %0d reserved code",
               n_add + n_remove + n_find + n_reserved, n_add, n_remove, n_find, n_reserved);
      $display("Find hits %0d, remove hits %0d, responses with store full %0d",
               find_hits, remove_hits, full_seen);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // ---------------------------------------------------------------- driver
   always @(posedge clock) begin
      bit             offer;
      record_req_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         offer = pending_requests.size() != 0 && (calm || $urandom_range(0, 99) >= 31);
         if (offer) begin
            nxt = pending_requests.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= nxt.op;
            req_tdata  <= {4'b0, nxt.pos, nxt.length, nxt.handle};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response side: random stalls plus one long hold-off counted here
   always @(posedge clock) begin
      int unsigned hold_left, hold_seen;
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  = 0;
         hold_seen  = hold_trigger;
      end else if (hold_seen != hold_trigger) begin
         hold_seen  = hold_trigger;
         hold_left  = LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= calm || $urandom_range(0, 99) >= 31;
      end
   end

   // ---------------------------------------------------------------- monitor
   task automatic note_mismatch(input string field, input logic [63:0] want,
                                input logic [63:0] got);
      errors++;
      if (errors <= 10)
         $display("response %0d %s: expected %0h, got %0h", rsp_index, field, want, got);
   endtask

   always @(posedge clock) begin
      record_rsp_type got, want;
      record_req_type req;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got = '{hit: rsp_tuser, handle: rsp_tdata[31:0], length: rsp_tdata[47:32],
                    offset: rsp_tdata[63:48], count: rsp_tdata[64 +: CNT_W],
                    full: rsp_tdata[64 + CNT_W]};
            if (expected_responses.size() == 0) begin
               note_mismatch("with no request outstanding", '0, 64'(got.count));
            end else begin
               want = expected_responses.pop_front();
               if (got.hit !== want.hit)
                  note_mismatch("hit", 64'(want.hit), 64'(got.hit));
               if (got.handle !== want.handle)
                  note_mismatch("handle", 64'(want.handle), 64'(got.handle));
               if (got.length !== want.length)
                  note_mismatch("length", 64'(want.length), 64'(got.length));
               if (got.offset !== want.offset)
                  note_mismatch("offset", 64'(want.offset), 64'(got.offset));
               if (got.count !== want.count)
                  note_mismatch("count", 64'(want.count), 64'(got.count));
               if (got.full !== want.full)
                  note_mismatch("full", 64'(want.full), 64'(got.full));
               if (want.full) full_seen++;
            end
            rsp_index++;
         end
         if (req_tvalid && req_tready) begin
            req  = '{op: req_tuser, handle: req_tdata[31:0], length: req_tdata[47:32],
                     pos: req_tdata[67:48]};
            want = apply_record_request(store_model, req);
            expected_responses.push_back(want);
            case (req.op)
               REQ_ADD:    n_add++;
               REQ_REMOVE: begin n_remove++; if (want.hit) remove_hits++; end
               REQ_FIND:   begin n_find++;   if (want.hit) find_hits++;   end
               default:    n_reserved++;
            endcase
         end
         if ((rsp_tvalid && rsp_tready) || (req_tvalid && req_tready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
      end
   end

   // watchdog: no handshake on either side for too long
   initial begin
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("Handshakes stopped for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
